@@ sv/aup2_pkg.sv @@
// Shared types and constants for the upsample-by-two interpolator.
package aup2_pkg;

  localparam int unsigned SMP_W   = 16;
  localparam int unsigned FMT_W   = 3;
  localparam int unsigned MAX_RES = 4;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned IDX_W   = 2;

  localparam logic [FMT_W-1:0] FMT_U8    = 3'd0;
  localparam logic [FMT_W-1:0] FMT_S8    = 3'd1;
  localparam logic [FMT_W-1:0] FMT_S16   = 3'd2;
  localparam logic [FMT_W-1:0] FMT_U16   = 3'd3;
  localparam logic [FMT_W-1:0] FMT_DUP16 = 3'd4;

  localparam logic signed [18:0] U8_LO  = 19'sd0;
  localparam logic signed [18:0] U8_HI  = 19'sd255;
  localparam logic signed [18:0] S8_LO  = -19'sd128;
  localparam logic signed [18:0] S8_HI  = 19'sd127;
  localparam logic signed [18:0] S16_LO = -19'sd32768;
  localparam logic signed [18:0] S16_HI = 19'sd32767;
  localparam logic signed [18:0] U16_LO = 19'sd0;
  localparam logic signed [18:0] U16_HI = 19'sd65535;

  typedef struct packed {
    logic [CNT_W-1:0]                cnt;
    logic [MAX_RES-1:0][SMP_W-1:0]   smp;
    logic [MAX_RES-1:0]              done;
  } res_set_t;

endpackage

@@ sv/audio_upsample_by_two_interp.sv @@
// Top level of the upsample-by-two linear interpolator.
// An item is first registered, then its results are loaded into the result buffer and
// handed out from there, one result per cycle while out_stall is low. An item that
// only gets held yields no results; the result buffer drain sets the rate.
// Reset (synchronous, rst_n low): nothing held, buffers empty, sample_format signed 16.
module audio_upsample_by_two_interp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [aup2_pkg::FMT_W-1:0] cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [aup2_pkg::SMP_W-1:0] in_sample_in,
  input  logic                       in_end_of_run,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [aup2_pkg::SMP_W-1:0] out_sample_out,
  output logic                       out_run_done
);

  logic [aup2_pkg::FMT_W-1:0] fmt_r;
  logic                       in_valid_r;
  logic [aup2_pkg::SMP_W-1:0] smp_r;
  logic                       last_r;
  logic [aup2_pkg::SMP_W-1:0] held_r;
  logic                       held_valid_r;
  logic                       held_valid_nxt;
  logic                       can_load;
  logic                       consume;
  logic                       accept;
  aup2_pkg::res_set_t         res;

  assign consume  = in_valid_r && can_load;
  assign in_stall = in_valid_r && !can_load;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r        <= aup2_pkg::FMT_S16;
      in_valid_r   <= 1'b0;
      held_valid_r <= 1'b0;
      held_r       <= '0;
    end else begin
      if (cfg_wr_en) begin
        fmt_r <= cfg_wr_data;
      end
      in_valid_r <= (in_valid_r && !consume) || accept;
      if (consume) begin
        held_valid_r <= held_valid_nxt;
        held_r       <= smp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      smp_r  <= in_sample_in;
      last_r <= in_end_of_run;
    end
  end

  aup2_calc u_calc (
    .smp            (smp_r),
    .last           (last_r),
    .held           (held_r),
    .held_valid     (held_valid_r),
    .fmt            (fmt_r),
    .res            (res),
    .held_valid_nxt (held_valid_nxt)
  );

  aup2_res_buf u_res_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (consume),
    .load_set   (res),
    .can_load   (can_load),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample_out),
    .out_done   (out_run_done)
  );

  stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_valid_r)
    else $error("input stalled with empty input register");

  run_end_clears_hold: assert property (@(posedge clk) disable iff (!rst_n)
    consume && last_r |=> !held_valid_r)
    else $error("sample still held after end of run");

  mid_run_holds_sample: assert property (@(posedge clk) disable iff (!rst_n)
    consume && !last_r && (fmt_r == aup2_pkg::FMT_S16) |=>
      held_valid_r && (held_r == $past(smp_r)))
    else $error("mid-run sample not held");

endmodule

@@ sv/aup2_calc.sv @@
// Result computation for one item: interpolation, extrapolation and duplication.
module aup2_calc (
  input  logic [aup2_pkg::SMP_W-1:0] smp,
  input  logic                       last,
  input  logic [aup2_pkg::SMP_W-1:0] held,
  input  logic                       held_valid,
  input  logic [aup2_pkg::FMT_W-1:0] fmt,
  output aup2_pkg::res_set_t         res,
  output logic                       held_valid_nxt
);

  logic              dup;
  logic              narrow;
  logic signed [16:0] s_dec;
  logic signed [16:0] h_dec;
  logic signed [17:0] sum;
  logic signed [17:0] mean;
  logic signed [17:0] diff;
  logic signed [17:0] quot;
  logic signed [18:0] ex;
  logic signed [18:0] lo;
  logic signed [18:0] hi;
  logic signed [18:0] ex_sat;
  logic [aup2_pkg::SMP_W-1:0] enc_h;
  logic [aup2_pkg::SMP_W-1:0] enc_s;
  logic [aup2_pkg::SMP_W-1:0] enc_mean;
  logic [aup2_pkg::SMP_W-1:0] enc_ex;

  function automatic logic signed [16:0] decode(input logic [15:0] raw,
                                                input logic [2:0] f);
    logic signed [16:0] v;
    case (f)
      aup2_pkg::FMT_U8:  v = $signed({9'd0, raw[7:0]});
      aup2_pkg::FMT_S8:  v = $signed({{9{raw[7]}}, raw[7:0]});
      aup2_pkg::FMT_S16: v = $signed({raw[15], raw});
      default:           v = $signed({1'b0, raw});
    endcase
    return v;
  endfunction

  assign dup    = (fmt != aup2_pkg::FMT_U8) && (fmt != aup2_pkg::FMT_S8) &&
                  (fmt != aup2_pkg::FMT_S16) && (fmt != aup2_pkg::FMT_U16);
  assign narrow = (fmt == aup2_pkg::FMT_U8) || (fmt == aup2_pkg::FMT_S8);

  always_comb begin
    s_dec = decode(smp, fmt);
    h_dec = decode(held, fmt);
    sum   = $signed({s_dec[16], s_dec}) + $signed({h_dec[16], h_dec});
    mean  = (sum + $signed({17'd0, sum[17]})) >>> 1;
    diff  = $signed({s_dec[16], s_dec}) - $signed({h_dec[16], h_dec});
    quot  = (diff + (diff[17] ? 18'sd7 : 18'sd0)) >>> 3;
    ex    = $signed({{2{s_dec[16]}}, s_dec}) + $signed({quot[17], quot});
    unique case (fmt)
      aup2_pkg::FMT_U8:  begin lo = aup2_pkg::U8_LO;  hi = aup2_pkg::U8_HI;  end
      aup2_pkg::FMT_S8:  begin lo = aup2_pkg::S8_LO;  hi = aup2_pkg::S8_HI;  end
      aup2_pkg::FMT_S16: begin lo = aup2_pkg::S16_LO; hi = aup2_pkg::S16_HI; end
      default:           begin lo = aup2_pkg::U16_LO; hi = aup2_pkg::U16_HI; end
    endcase
    if (!held_valid) begin
      ex_sat = $signed({{2{s_dec[16]}}, s_dec});
    end else if (ex > hi) begin
      ex_sat = hi;
    end else if (ex < lo) begin
      ex_sat = lo;
    end else begin
      ex_sat = ex;
    end
    enc_h    = narrow ? {8'd0, held[7:0]}   : held;
    enc_s    = narrow ? {8'd0, smp[7:0]}    : smp;
    enc_mean = narrow ? {8'd0, mean[7:0]}   : mean[15:0];
    enc_ex   = narrow ? {8'd0, ex_sat[7:0]} : ex_sat[15:0];

    res      = '0;
    held_valid_nxt = 1'b0;
    if (dup) begin
      if (held_valid) begin
        res.cnt     = 3'd4;
        res.smp[0]  = held;
        res.smp[1]  = held;
        res.smp[2]  = smp;
        res.smp[3]  = smp;
        res.done[3] = last;
      end else begin
        res.cnt     = 3'd2;
        res.smp[0]  = smp;
        res.smp[1]  = smp;
        res.done[1] = last;
      end
    end else if (held_valid) begin
      res.smp[0] = enc_h;
      res.smp[1] = enc_mean;
      if (last) begin
        res.cnt     = 3'd4;
        res.smp[2]  = enc_s;
        res.smp[3]  = enc_ex;
        res.done[3] = 1'b1;
      end else begin
        res.cnt        = 3'd2;
        held_valid_nxt = 1'b1;
      end
    end else if (last) begin
      res.cnt     = 3'd2;
      res.smp[0]  = enc_s;
      res.smp[1]  = enc_ex;
      res.done[1] = 1'b1;
    end else begin
      held_valid_nxt = 1'b1;
    end
  end

endmodule

@@ sv/aup2_res_buf.sv @@
// Result buffer: holds the results of one item and hands them out in order.
module aup2_res_buf (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  aup2_pkg::res_set_t         load_set,
  output logic                       can_load,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [aup2_pkg::SMP_W-1:0] out_sample,
  output logic                       out_done
);

  aup2_pkg::res_set_t             set_r;
  logic [aup2_pkg::CNT_W-1:0]     pend_r;
  logic [aup2_pkg::CNT_W-1:0]     pend_nxt;
  logic [aup2_pkg::IDX_W-1:0]     idx_r;
  logic [aup2_pkg::IDX_W-1:0]     idx_nxt;
  logic                           fire;

  assign out_valid  = (pend_r != '0);
  assign fire       = out_valid && !out_stall;
  assign can_load   = (pend_r == '0) || ((pend_r == 3'd1) && fire);
  assign out_sample = set_r.smp[idx_r];
  assign out_done   = set_r.done[idx_r];

  always_comb begin
    pend_nxt = pend_r;
    idx_nxt  = idx_r;
    if (load) begin
      pend_nxt = load_set.cnt;
      idx_nxt  = '0;
    end else if (fire) begin
      pend_nxt = pend_r - 3'd1;
      idx_nxt  = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      idx_r  <= '0;
    end else begin
      pend_r <= pend_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      set_r <= load_set;
    end
  end

  pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'd4)
    else $error("result count out of range");

  load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> can_load)
    else $error("result buffer overwritten");

  drain_advances: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !load |=> pend_r == $past(pend_r) - 3'd1)
    else $error("result count did not advance");

endmodule

@@ tb/audio_upsample_by_two_interp_test.sv @@
// Self-checking testbench for the upsample-by-two linear interpolator.
`timescale 1ns / 100ps

module audio_upsample_by_two_interp_test;

  localparam logic [aup2_pkg::FMT_W-1:0] FMT_DUP_ALT5 = 3'd5;
  localparam logic [aup2_pkg::FMT_W-1:0] FMT_DUP_ALT6 = 3'd6;
  localparam logic [aup2_pkg::FMT_W-1:0] FMT_DUP_ALT7 = 3'd7;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 6;

  typedef struct packed {
    logic [aup2_pkg::SMP_W-1:0] smp;
    logic                       done;
  } upsample_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [aup2_pkg::FMT_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [aup2_pkg::SMP_W-1:0] in_sample_in = '0;
  logic in_end_of_run = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [aup2_pkg::SMP_W-1:0] out_sample_out;
  logic out_run_done;

  upsample_res_t pending_samples[$];
  logic [aup2_pkg::FMT_W-1:0] cur_format = aup2_pkg::FMT_S16;
  logic [aup2_pkg::SMP_W-1:0] held_bits = '0;
  logic held_vld = 1'b0;
  int mismatch_count = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  logic long_hold_req = 1'b0;
  int long_hold_left = 0;
  int quiet_cycles = 0;

  audio_upsample_by_two_interp DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample_in  (in_sample_in),
    .in_end_of_run (in_end_of_run),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sample_out(out_sample_out),
    .out_run_done  (out_run_done)
  );

  always #6 clk = ~clk;

  function automatic int to_level(logic [aup2_pkg::SMP_W-1:0] raw,
                                  logic [aup2_pkg::FMT_W-1:0] fmt);
    case (fmt)
      aup2_pkg::FMT_U8:  return int'(raw[7:0]);
      aup2_pkg::FMT_S8:  return int'($signed(raw[7:0]));
      aup2_pkg::FMT_S16: return int'($signed(raw));
      default:           return int'(raw);
    endcase
  endfunction

  function automatic logic [aup2_pkg::SMP_W-1:0] from_level(int v,
                                                            logic [aup2_pkg::FMT_W-1:0] fmt);
    if (fmt <= aup2_pkg::FMT_S8) return {8'h00, v[7:0]};
    return v[15:0];
  endfunction

  function automatic int clamp_level(int v, logic [aup2_pkg::FMT_W-1:0] fmt);
    int lo, hi;
    case (fmt)
      aup2_pkg::FMT_U8: begin
        lo = int'(aup2_pkg::U8_LO);  hi = int'(aup2_pkg::U8_HI);
      end
      aup2_pkg::FMT_S8: begin
        lo = int'(aup2_pkg::S8_LO);  hi = int'(aup2_pkg::S8_HI);
      end
      aup2_pkg::FMT_S16: begin
        lo = int'(aup2_pkg::S16_LO); hi = int'(aup2_pkg::S16_HI);
      end
      default: begin
        lo = int'(aup2_pkg::U16_LO); hi = int'(aup2_pkg::U16_HI);
      end
    endcase
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic void push_result(logic [aup2_pkg::SMP_W-1:0] smp, logic done);
    upsample_res_t r;
    r.smp = smp;
    r.done = done;
    pending_samples.push_back(r);
  endfunction

  function automatic void interpolate_item(logic [aup2_pkg::SMP_W-1:0] raw, logic run_end);
    int s, h, ex;
    if (cur_format >= aup2_pkg::FMT_DUP16) begin
      if (held_vld) begin
        push_result(held_bits, 1'b0);
        push_result(held_bits, 1'b0);
      end
      push_result(raw, 1'b0);
      push_result(raw, run_end);
      held_bits = raw;
      held_vld = 1'b0;
      return;
    end
    s = to_level(raw, cur_format);
    h = to_level(held_bits, cur_format);
    if (held_vld) begin
      push_result(from_level(h, cur_format), 1'b0);
      push_result(from_level((h + s) / 2, cur_format), 1'b0);
    end
    if (run_end) begin
      ex = held_vld ? clamp_level(s + (s - h) / 8, cur_format) : s;
      push_result(from_level(s, cur_format), 1'b0);
      push_result(from_level(ex, cur_format), 1'b1);
      held_vld = 1'b0;
    end else begin
      held_vld = 1'b1;
    end
    held_bits = raw;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Check each result against the oldest expectation.
  always @(posedge clk) begin : check_results
    upsample_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_samples.size() == 0) begin
        report_mismatch($sformatf("unexpected item sample %h done %b",
                                  out_sample_out, out_run_done));
      end else begin
        want = pending_samples.pop_front();
        if (out_sample_out !== want.smp)
          report_mismatch($sformatf("sample_out %h, want %h", out_sample_out, want.smp));
        if (out_run_done !== want.done)
          report_mismatch($sformatf("run_done %b, want %b", out_run_done, want.done));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (long_hold_left != 0) begin
      out_stall <= 1'b1;
      long_hold_left <= long_hold_left - 1;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      out_stall <= 1'b1;
      long_hold_left <= LONG_HOLD_CYCLES;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("audio_upsample_by_two_interp_test failed");
        $finish;
      end
    end
  end

  task automatic send_sample(logic [aup2_pkg::SMP_W-1:0] smp, logic run_end);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_in <= smp;
    in_end_of_run <= run_end;
    do @(posedge clk); while (in_stall);
    interpolate_item(smp, run_end);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_format(logic [aup2_pkg::FMT_W-1:0] fmt);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= fmt;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_format = fmt;
  endtask

  function automatic logic [aup2_pkg::SMP_W-1:0] pick_sample();
    if ($urandom_range(5) != 0) return 16'($urandom);
    case ($urandom_range(6))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h7FFF;
      3: return 16'h8000;
      4: return 16'h00FF;
      5: return 16'h0080;
      default: return 16'h007F;
    endcase
  endfunction

  function automatic logic [aup2_pkg::FMT_W-1:0] pick_format();
    if ($urandom_range(9) < 8)
      return 3'($urandom_range(aup2_pkg::FMT_DUP16, aup2_pkg::FMT_U8));
    return 3'($urandom_range(FMT_DUP_ALT7, FMT_DUP_ALT5));
  endfunction

  task automatic test_signed16_edges();
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b1);
    send_sample(16'hFFFD, 1'b0);
    send_sample(16'h0000, 1'b1);
  endtask

  task automatic test_eight_bit();
    write_format(aup2_pkg::FMT_U8);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0000, 1'b1);
    write_format(aup2_pkg::FMT_S8);
    send_sample(16'h0080, 1'b0);
    send_sample(16'hFF7F, 1'b1);
  endtask

  task automatic test_unsigned16();
    write_format(aup2_pkg::FMT_U16);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b1);
  endtask

  task automatic test_single_sample_run();
    write_format(aup2_pkg::FMT_S16);
    send_sample(16'h1234, 1'b1);
  endtask

  task automatic test_format_switch_held();
    send_sample(16'h8000, 1'b0);
    write_format(aup2_pkg::FMT_U8);
    send_sample(16'h0010, 1'b1);
  endtask

  task automatic test_duplicate();
    write_format(aup2_pkg::FMT_DUP16);
    send_sample(16'hABCD, 1'b0);
    send_sample(16'h1357, 1'b1);
    write_format(aup2_pkg::FMT_S16);
    send_sample(16'h4000, 1'b0);
    write_format(FMT_DUP_ALT5);
    send_sample(16'h00FF, 1'b1);
    write_format(FMT_DUP_ALT7);
    send_sample(16'h8001, 1'b1);
    write_format(FMT_DUP_ALT6);
    send_sample(16'h0001, 1'b0);
  endtask

  task automatic test_random_runs(int n_items, int tx_pct, int rx_pct);
    int sent, run_len;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(3) == 0) write_format(pick_format());
      run_len = int'($urandom_range(8, 1));
      for (int k = 0; k < run_len; k++) begin
        // leave a run open now and then
        send_sample(pick_sample(), (k == run_len - 1) && ($urandom_range(9) != 0));
        sent++;
      end
    end
  endtask

  task automatic test_backpressure();
    write_format(aup2_pkg::FMT_S16);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    long_hold_req = 1'b1;
    for (int k = 0; k < 12; k++) send_sample(pick_sample(), k == 11);
    wait_idle();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_signed16_edges();
    test_eight_bit();
    test_unsigned16();
    test_single_sample_run();
    test_format_switch_held();
    test_duplicate();
    test_random_runs(35, 21, 74);
    test_random_runs(35, 74, 21);
    test_backpressure();
    test_random_runs(30, 0, 0);
    wait_idle();
    repeat (20) @(posedge clk);
    if (pending_samples.size() != 0)
      report_mismatch($sformatf("%0d items never arrived", pending_samples.size()));
    if (mismatch_count == 0) begin
      $display("audio_upsample_by_two_interp_test passed");
    end else begin
      $display("audio_upsample_by_two_interp_test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/aup2_pkg.sv
sv/aup2_calc.sv
sv/aup2_res_buf.sv
sv/audio_upsample_by_two_interp.sv
tb/audio_upsample_by_two_interp_test.sv
